// ===== rtl/core/i2c_slave_transmit_sequencer_core_macros.svh =====
// ----------------------------------------------------------------------------
// i2c slave transmit sequencer assertion macros
// concurrent checks on clk, quiet while rst_n is low
// ----------------------------------------------------------------------------
`ifndef I2C_SLAVE_TRANSMIT_SEQUENCER_CORE_MACROS_SVH
`define I2C_SLAVE_TRANSMIT_SEQUENCER_CORE_MACROS_SVH

`ifndef SYNTH
`define I2CST_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2cst check failed");
`define I2CST_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2cst check failed");
`else
`define I2CST_ASSERT_NOW(lbl, ante, cons)
`define I2CST_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/core/i2cst_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cst_pkg
// shared types and constants of the i2c slave transmit sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package i2cst_pkg;

    localparam int BUFFER_DEPTH_DEF = 32;

    localparam int ACTION_W = 2;
    localparam int STATUS_W = 8;
    localparam int INDEX_W  = 5;
    localparam int BYTE_W   = 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD  = 2'd0,
        ACT_EVENT = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

    // status codes with the low three bits dropped
    localparam logic [4:0] ST_SLA_R_ACK   = 5'h15;  // 0xA8
    localparam logic [4:0] ST_ARB_SLA_R   = 5'h16;  // 0xB0
    localparam logic [4:0] ST_DATA_ACK    = 5'h17;  // 0xB8
    localparam logic [4:0] ST_DATA_NACK   = 5'h18;  // 0xC0
    localparam logic [4:0] ST_LAST_DATA   = 5'h19;  // 0xC8

    localparam logic [BYTE_W-1:0] TX_FILL = 8'h00;

    typedef struct packed {
        logic byte_valid;
        logic use_store;
        logic ack_enable;
        logic transmitting;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/i2cst_store.sv =====
// ----------------------------------------------------------------------------
// i2cst_store
// reply byte store, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module i2cst_store
    import i2cst_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
    localparam int AW = $clog2(BUFFER_DEPTH)
)
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire logic [BYTE_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [AW-1:0]     rd_addr,
    output logic      [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] mem [BUFFER_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/i2cst_ctrl.sv =====
// ----------------------------------------------------------------------------
// i2cst_ctrl
// staging and send state, decodes one transaction per cycle while go is high
// ----------------------------------------------------------------------------
`default_nettype none

module i2cst_ctrl
    import i2cst_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
    localparam int AW = $clog2(BUFFER_DEPTH),
    localparam int CW = $clog2(BUFFER_DEPTH + 1),
    localparam int LW = (CW > INDEX_W) ? CW : INDEX_W
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                go,
    input  wire logic [ACTION_W-1:0] action,
    input  wire logic [STATUS_W-1:0] bus_status,
    input  wire logic [INDEX_W-1:0]  load_index,
    input  wire logic [BYTE_W-1:0]   load_byte,
    input  wire logic                load_last,
    output logic                     has_result,
    output result_t                  result,
    output logic                     wr_en,
    output logic      [AW-1:0]       wr_addr,
    output logic      [BYTE_W-1:0]   wr_data,
    output logic                     rd_en,
    output logic      [AW-1:0]       rd_addr
);

    logic [CW-1:0] staged_count_reg, staged_count_next;
    logic [CW-1:0] send_count_reg, send_count_next;
    logic [CW-1:0] send_position_reg, send_position_next;
    logic          in_transmit_reg, in_transmit_next;

    logic [LW-1:0] idx_wide;
    logic          load_ok;
    logic          is_event;
    logic          enter;
    logic          step;
    logic          leave;
    logic [CW-1:0] pos_cur;
    logic [CW-1:0] cnt_cur;
    logic [CW-1:0] pos_new;
    logic          in_range;

    assign idx_wide = LW'(load_index);
    assign load_ok  = idx_wide < LW'(BUFFER_DEPTH);
    assign is_event = go && (action_t'(action) == ACT_EVENT);

    always_comb
    begin
        enter = 1'b0;
        step  = 1'b0;
        leave = 1'b0;
        unique case (bus_status[7:3])
            ST_SLA_R_ACK, ST_ARB_SLA_R: enter = is_event;
            ST_DATA_ACK:                step  = is_event && in_transmit_reg;
            ST_DATA_NACK, ST_LAST_DATA: leave = is_event;
            default:                    ;
        endcase
    end

    assign pos_cur  = enter ? '0 : send_position_reg;
    assign cnt_cur  = enter ? staged_count_reg : send_count_reg;
    assign in_range = pos_cur < cnt_cur;
    assign pos_new  = (pos_cur < CW'(BUFFER_DEPTH)) ? pos_cur + CW'(1) : pos_cur;

    assign wr_en   = go && (action_t'(action) == ACT_LOAD) && load_ok;
    assign wr_addr = idx_wide[AW-1:0];
    assign wr_data = load_byte;
    assign rd_en   = (enter || step) && in_range;
    assign rd_addr = pos_cur[AW-1:0];

    always_comb
    begin
        staged_count_next  = staged_count_reg;
        send_count_next    = send_count_reg;
        send_position_next = send_position_reg;
        in_transmit_next   = in_transmit_reg;
        has_result         = 1'b0;
        result             = '0;

        if (wr_en && load_last)
        begin
            staged_count_next = CW'(idx_wide) + CW'(1);
        end

        if (go && (action_t'(action) == ACT_CLEAR))
        begin
            staged_count_next = '0;
        end

        if (enter || step)
        begin
            in_transmit_next    = 1'b1;
            send_count_next     = cnt_cur;
            send_position_next  = pos_new;
            has_result          = 1'b1;
            result.byte_valid   = 1'b1;
            result.use_store    = in_range;
            result.ack_enable   = pos_new < cnt_cur;
            result.transmitting = 1'b1;
        end

        if (leave)
        begin
            in_transmit_next    = 1'b0;
            has_result          = 1'b1;
            result.ack_enable   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            staged_count_reg  <= '0;
            send_count_reg    <= '0;
            send_position_reg <= '0;
            in_transmit_reg   <= 1'b0;
        end
        else
        begin
            staged_count_reg  <= staged_count_next;
            send_count_reg    <= send_count_next;
            send_position_reg <= send_position_next;
            in_transmit_reg   <= in_transmit_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/i2c_slave_transmit_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// i2c_slave_transmit_sequencer_core
// slave transmit reply sequencer: stages reply bytes and hands them out on
// bus status events
// ----------------------------------------------------------------------------
// Takes one transaction every clock cycle while in_stall is low. Each
// transaction passes through the input register and then the result
// register, which is loaded together with the registered read of the reply
// store. A stall on the output holds both registers; the input side still
// takes a transaction while its own register is empty. Loads, clears and
// unknown status codes give no result. The reply store is not cleared after
// reset; entries are defined once loaded.
`default_nettype none

`include "i2c_slave_transmit_sequencer_core_macros.svh"

module i2c_slave_transmit_sequencer_core
    import i2cst_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [ACTION_W-1:0] action,
    input  wire logic [STATUS_W-1:0] bus_status,
    input  wire logic [INDEX_W-1:0]  load_index,
    input  wire logic [BYTE_W-1:0]   load_byte,
    input  wire logic                load_last,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic                     byte_valid,
    output logic      [BYTE_W-1:0]   tx_byte,
    output logic                     ack_enable,
    output logic                     transmitting
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    logic                in_vld_reg, in_vld_next;
    logic [ACTION_W-1:0] action_reg;
    logic [STATUS_W-1:0] bus_status_reg;
    logic [INDEX_W-1:0]  load_index_reg;
    logic [BYTE_W-1:0]   load_byte_reg;
    logic                load_last_reg;

    logic                out_vld_reg, out_vld_next;
    result_t             result_reg;

    logic                advance;
    logic                in_take;
    logic                go;
    logic                has_result;
    result_t             result;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [BYTE_W-1:0]   wr_data;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [BYTE_W-1:0]   rd_data;

    assign advance  = !out_vld_reg || !out_stall;
    assign in_stall = in_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;
    assign go       = in_vld_reg && advance;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_take)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end
        out_vld_next = advance ? (go && has_result) : out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            action_reg     <= action;
            bus_status_reg <= bus_status;
            load_index_reg <= load_index;
            load_byte_reg  <= load_byte;
            load_last_reg  <= load_last;
        end
        if (advance)
        begin
            result_reg <= result;
        end
    end

    i2cst_ctrl #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (go),
        .action     (action_reg),
        .bus_status (bus_status_reg),
        .load_index (load_index_reg),
        .load_byte  (load_byte_reg),
        .load_last  (load_last_reg),
        .has_result (has_result),
        .result     (result),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr)
    );

    i2cst_store #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en && advance),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_valid    = out_vld_reg;
    assign byte_valid   = result_reg.byte_valid;
    assign tx_byte      = result_reg.use_store ? rd_data : TX_FILL;
    assign ack_enable   = result_reg.ack_enable;
    assign transmitting = result_reg.transmitting;

    // leaving transmit carries no byte and restores acknowledge
    `I2CST_ASSERT_NOW(a_leave_shape, out_valid && !byte_valid, ack_enable && !transmitting && (tx_byte == TX_FILL))
    // a sent byte always belongs to a transfer
    `I2CST_ASSERT_NOW(a_byte_in_tx, out_valid && byte_valid, transmitting)
    // the input side only backs up behind a stalled result
    `I2CST_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)
    // a stalled result keeps its byte
    `I2CST_ASSERT_NEXT(a_hold_byte, out_valid && out_stall, $stable(tx_byte) && $stable(ack_enable))

endmodule

`default_nettype wire
